[hw/rtl/exptok_pkg.sv]
// Package for the expression tokenizer: scanner modes, token and error codes,
// character constants, byte classes and the token record.
// Depends on nothing; used by expression_tokenizer.
`default_nettype none

package exptok_pkg;

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_LT, M_GT, M_EQ, M_BANG, M_NUM_INT, M_NUM_FRAC,
        M_COLON, M_SYM, M_WORD
    } t_mode;

    typedef enum logic [4:0] {
        K_PLUS, K_MINUS, K_STAR, K_SLASH, K_LPAREN, K_RPAREN, K_END, K_LE,
        K_LT, K_GE, K_GT, K_EQEQ, K_EQ, K_NE, K_NUM, K_SYM, K_AND, K_FALSE,
        K_NOT, K_NONE, K_TRUE, K_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE, E_BAD_SYM, E_IDENT, E_LONE_BANG, E_BAD_BYTE
    } t_err;

    typedef struct packed {
        t_kind       kind;
        t_err        err;
        logic [15:0] off;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } t_token;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GREAT  = 8'h3E;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    // Keywords, first letter in the top byte, padded with zero bytes
    localparam logic [39:0] KW_AND   = {"and", 16'h0000};
    localparam logic [39:0] KW_FALSE = "false";
    localparam logic [39:0] KW_NOT   = {"not", 16'h0000};
    localparam logic [39:0] KW_NONE  = {"none", 8'h00};
    localparam logic [39:0] KW_TRUE  = {"true", 8'h00};

    function automatic logic is_numeral(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_first(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == CH_USCORE);
    endfunction

    function automatic logic is_rest(input logic [7:0] b);
        return is_first(b) || is_numeral(b) || (b == CH_BANG) || (b == CH_QUEST);
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b inside {CH_SPACE, CH_LF, CH_CR, CH_TAB, CH_VT};
    endfunction

endpackage

`default_nettype wire

[hw/rtl/expression_tokenizer.sv]
// Streaming lexer for a small expression language: one source byte in, up to
// two tokens out per byte. Depends on exptok_pkg.
//
//  channel   | dir | fields (lowest bit first)
//  ----------+-----+---------------------------------------------------------
//  s_axis    | in  | tdata[7:0] text_byte (0 = end of text)
//  m_axis    | out | tdata offset[15:0] length[31:16] line[47:32];
//            |     | tuser token_kind[4:0] error_kind[7:5]; tlast last_of_run
//
// Cycles: a byte is scanned in the cycle it is accepted; its tokens reach the
// output queue at that edge and the first can leave on the next edge.
// Sustained rate is one byte per cycle while m_axis is ready and each byte gives
// at most one token; a two-token byte holds the input until one has gone out.
// Reset (i_rst_n low, synchronous) empties the queue and sets offset 0, line 1.
// Stalls: the input is taken while the three-entry output queue holds at most
// one token, so a waiting result never blocks the next byte by itself.
`default_nettype none

module expression_tokenizer #(
    parameter longint unsigned TEXT_LIMIT = 65535
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // text_byte[7:0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // token_offset[15:0], token_length[31:16],
                                          // line_number[47:32]
    output logic [7:0]  o_m_axis_tuser,   // token_kind[4:0], error_kind[7:5]
    output logic        o_m_axis_tlast    // last_of_run
);
    import exptok_pkg::*;

    // Position width follows the saturation limit
    localparam int POS_W = $clog2(TEXT_LIMIT + 64'd1);
    localparam int EXT_W = (POS_W > 16) ? POS_W : 16;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(TEXT_LIMIT);
    localparam int Q_DEPTH = 3;

    // Scanner state
    t_mode            r_mode,  n_mode;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [POS_W-1:0] r_begin, n_begin;
    logic [15:0]      r_line,  n_line;
    logic [7:0]       r_word [5];
    logic [7:0]       n_word [5];
    logic [2:0]       r_wlen,  n_wlen;

    // Output queue, head in slot 0
    t_token           r_q [Q_DEPTH];
    t_token           n_q [Q_DEPTH];
    t_token           w_sh [Q_DEPTH];
    logic [1:0]       r_cnt, n_cnt;
    logic [1:0]       w_c0;

    logic             w_acc, w_pop, w_again;
    logic [7:0]       w_b;
    logic [POS_W-1:0] w_p1;
    t_token           w_tok_a, w_tok_b, w_e0, w_e1;
    logic             w_has_a, w_has_b;
    logic [1:0]       w_np;

    function automatic logic [15:0] clamp16(input logic [POS_W-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return (ext > EXT_W'(17'h0FFFF)) ? 16'hFFFF : ext[15:0];
    endfunction

    function automatic logic [15:0] span(input logic [POS_W-1:0] e,
                                         input logic [POS_W-1:0] s);
        return (e >= s) ? clamp16(e - s) : 16'd0;
    endfunction

    function automatic t_token mk_tok(input t_kind k, input t_err e,
                                      input logic [15:0] off, input logic [15:0] len,
                                      input logic [15:0] line);
        t_token t;
        t.kind = k;
        t.err  = e;
        t.off  = off;
        t.len  = len;
        t.line = line;
        t.last = 1'b0;
        return t;
    endfunction

    assign w_b   = i_s_axis_tdata;
    assign w_acc = i_s_axis_tvalid & o_s_axis_tready;
    assign w_pop = o_m_axis_tvalid & i_m_axis_tready;
    assign w_p1  = (r_pos >= POS_MAX) ? POS_MAX : r_pos + 1'b1;

    // Token generation: first the pending token closed by this byte, then the
    // token the byte gives when scanned afresh.
    always_comb begin
        t_kind       k_two;
        t_kind       k_one;
        logic [39:0] word;
        t_kind       k_word;
        w_has_a = 1'b0;
        w_tok_a = '0;
        w_again = 1'b0;
        k_two   = K_EQEQ;
        k_one   = K_EQ;
        word    = {r_word[0], r_word[1], r_word[2], r_word[3], r_word[4]};
        k_word  = K_ERROR;
        if (r_wlen == 3'd3 && word == KW_AND) begin
            k_word = K_AND;
        end else if (r_wlen == 3'd5 && word == KW_FALSE) begin
            k_word = K_FALSE;
        end else if (r_wlen == 3'd3 && word == KW_NOT) begin
            k_word = K_NOT;
        end else if (r_wlen == 3'd4 && word == KW_NONE) begin
            k_word = K_NONE;
        end else if (r_wlen == 3'd4 && word == KW_TRUE) begin
            k_word = K_TRUE;
        end
        case (r_mode)
            M_LT: begin
                k_two = K_LE;
                k_one = K_LT;
            end
            M_GT: begin
                k_two = K_GE;
                k_one = K_GT;
            end
            default: begin
                k_two = K_EQEQ;
                k_one = K_EQ;
            end
        endcase

        case (r_mode)
            M_COMMENT: begin
                w_again = (w_b == CH_LF) || (w_b == CH_NUL);
            end
            M_LT, M_GT, M_EQ: begin
                w_has_a = 1'b1;
                if (w_b == CH_EQ) begin
                    w_tok_a = mk_tok(k_two, E_NONE, clamp16(r_begin), span(w_p1, r_begin), r_line);
                end else begin
                    w_tok_a = mk_tok(k_one, E_NONE, clamp16(r_begin), span(r_pos, r_begin), r_line);
                    w_again = 1'b1;
                end
            end
            M_BANG: begin
                w_has_a = 1'b1;
                if (w_b == CH_EQ) begin
                    w_tok_a = mk_tok(K_NE, E_NONE, clamp16(r_begin), span(w_p1, r_begin), r_line);
                end else begin
                    w_tok_a = mk_tok(K_ERROR, E_LONE_BANG, 16'd0, 16'd0, r_line);
                    w_again = 1'b1;
                end
            end
            M_NUM_INT, M_NUM_FRAC: begin
                if (!is_numeral(w_b) && !(r_mode == M_NUM_INT && w_b == CH_DOT)) begin
                    w_has_a = 1'b1;
                    w_tok_a = mk_tok(K_NUM, E_NONE, clamp16(r_begin), span(r_pos, r_begin), r_line);
                    w_again = 1'b1;
                end
            end
            M_COLON: begin
                if (!is_first(w_b)) begin
                    w_has_a = 1'b1;
                    w_tok_a = mk_tok(K_ERROR, E_BAD_SYM, 16'd0, 16'd0, r_line);
                    w_again = 1'b1;
                end
            end
            M_SYM: begin
                if (!is_rest(w_b)) begin
                    w_has_a = 1'b1;
                    w_tok_a = mk_tok(K_SYM, E_NONE, clamp16(r_begin), span(r_pos, r_begin), r_line);
                    w_again = 1'b1;
                end
            end
            M_WORD: begin
                if (!is_rest(w_b)) begin
                    w_has_a = 1'b1;
                    w_again = 1'b1;
                    if (k_word == K_ERROR) begin
                        w_tok_a = mk_tok(K_ERROR, E_IDENT, 16'd0, 16'd0, r_line);
                    end else begin
                        w_tok_a = mk_tok(k_word, E_NONE, clamp16(r_begin),
                                         span(r_pos, r_begin), r_line);
                    end
                end
            end
            default: begin
                w_again = 1'b1;
            end
        endcase

        // Fresh scan of the byte
        w_has_b = 1'b0;
        w_tok_b = '0;
        if (w_again) begin
            w_has_b = 1'b1;
            case (w_b)
                CH_NUL:    w_tok_b = mk_tok(K_END, E_NONE, clamp16(r_pos), 16'd1, r_line);
                CH_PLUS:   w_tok_b = mk_tok(K_PLUS, E_NONE, clamp16(r_pos), 16'd1, r_line);
                CH_MINUS:  w_tok_b = mk_tok(K_MINUS, E_NONE, clamp16(r_pos), 16'd1, r_line);
                CH_STAR:   w_tok_b = mk_tok(K_STAR, E_NONE, clamp16(r_pos), 16'd1, r_line);
                CH_SLASH:  w_tok_b = mk_tok(K_SLASH, E_NONE, clamp16(r_pos), 16'd1, r_line);
                CH_LPAREN: w_tok_b = mk_tok(K_LPAREN, E_NONE, clamp16(r_pos), 16'd1, r_line);
                CH_RPAREN: w_tok_b = mk_tok(K_RPAREN, E_NONE, clamp16(r_pos), 16'd1, r_line);
                CH_LESS, CH_GREAT, CH_EQ, CH_BANG, CH_HASH, CH_COLON: begin
                    w_has_b = 1'b0;
                end
                default: begin
                    w_has_b = !(is_blank(w_b) || is_numeral(w_b) || is_first(w_b));
                    w_tok_b = mk_tok(K_ERROR, E_BAD_BYTE, 16'd0, 16'd0, r_line);
                end
            endcase
        end
        w_tok_a.last = !w_has_b;
        w_tok_b.last = 1'b1;
    end

    // Next scanner state
    always_comb begin
        n_mode  = r_mode;
        n_pos   = w_p1;
        n_begin = r_begin;
        n_line  = r_line;
        n_word  = r_word;
        n_wlen  = r_wlen;
        case (r_mode)
            M_LT, M_GT, M_EQ, M_BANG: begin
                if (w_b == CH_EQ) n_mode = M_IDLE;
            end
            M_NUM_INT: begin
                if (w_b == CH_DOT) n_mode = M_NUM_FRAC;
            end
            M_COLON: begin
                if (is_first(w_b)) n_mode = M_SYM;
            end
            M_WORD: begin
                if (is_rest(w_b)) begin
                    for (int i = 0; i < 5; i++) begin
                        if (r_wlen == 3'(i)) n_word[i] = w_b;
                    end
                    if (r_wlen < 3'd6) n_wlen = r_wlen + 3'd1;
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase

        if (w_again) begin
            n_mode = M_IDLE;
            case (w_b)
                CH_NUL: begin
                    // End of text: drop back to the reset state
                    n_pos   = '0;
                    n_begin = '0;
                    n_line  = 16'd1;
                    n_wlen  = 3'd0;
                    for (int i = 0; i < 5; i++) n_word[i] = 8'h00;
                end
                CH_LESS: begin
                    n_begin = r_pos;
                    n_mode  = M_LT;
                end
                CH_GREAT: begin
                    n_begin = r_pos;
                    n_mode  = M_GT;
                end
                CH_EQ: begin
                    n_begin = r_pos;
                    n_mode  = M_EQ;
                end
                CH_BANG: begin
                    n_begin = r_pos;
                    n_mode  = M_BANG;
                end
                CH_HASH: begin
                    n_mode = M_COMMENT;
                end
                CH_COLON: begin
                    n_begin = w_p1;
                    n_mode  = M_COLON;
                end
                default: begin
                    if (is_blank(w_b)) begin
                        if (w_b == CH_LF && r_line != 16'hFFFF) n_line = r_line + 16'd1;
                    end else if (is_numeral(w_b)) begin
                        n_begin = r_pos;
                        n_mode  = M_NUM_INT;
                    end else if (is_first(w_b)) begin
                        n_begin = r_pos;
                        n_mode  = M_WORD;
                        n_word[0] = w_b;
                        for (int i = 1; i < 5; i++) n_word[i] = 8'h00;
                        n_wlen = 3'd1;
                    end
                end
            endcase
        end
    end

    // Queue update: shift out on a pop, then append the new tokens
    always_comb begin
        w_np = {1'b0, w_has_a} + {1'b0, w_has_b};
        if (!w_acc) w_np = 2'd0;
        w_e0 = w_has_a ? w_tok_a : w_tok_b;
        w_e1 = w_tok_b;
        w_c0 = r_cnt - {1'b0, w_pop};
        if (w_pop) begin
            w_sh[0] = r_q[1];
            w_sh[1] = r_q[2];
            w_sh[2] = r_q[2];
        end else begin
            w_sh = r_q;
        end
        for (int i = 0; i < Q_DEPTH; i++) begin
            if (2'(i) < w_c0) begin
                n_q[i] = w_sh[i];
            end else if (2'(i) == w_c0) begin
                n_q[i] = w_e0;
            end else begin
                n_q[i] = w_e1;
            end
        end
        n_cnt = w_c0 + w_np;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= '0;
            r_begin <= '0;
            r_line  <= 16'd1;
            r_wlen  <= 3'd0;
            for (int i = 0; i < 5; i++) r_word[i] <= 8'h00;
            r_cnt   <= 2'd0;
        end else begin
            if (w_acc) begin
                r_mode  <= n_mode;
                r_pos   <= n_pos;
                r_begin <= n_begin;
                r_line  <= n_line;
                r_word  <= n_word;
                r_wlen  <= n_wlen;
            end
            r_cnt <= n_cnt;
        end
    end

    // Payload slots carry no reset
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_s_axis_tready = (r_cnt <= 2'd1);
    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = {r_q[0].line, r_q[0].len, r_q[0].off};
    assign o_m_axis_tuser  = {r_q[0].err, r_q[0].kind};
    assign o_m_axis_tlast  = r_q[0].last;

`ifndef ASSERT_OFF
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_s_axis_tdata == CH_NUL)
        |=> (r_pos == '0 && r_line == 16'd1 && r_mode == M_IDLE))
        else $error("state not cleared after end of text");

    a_err_no_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[4:0] == K_ERROR)
        |-> (o_m_axis_tdata[31:0] == 32'd0 && o_m_axis_tuser[7:5] != E_NONE))
        else $error("error token with offset or length or no error code");

    a_ok_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[4:0] != K_ERROR)
        |-> (o_m_axis_tuser[7:5] == E_NONE))
        else $error("error code on a valid token");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_np == 2'd2) |-> (!w_e0.last && w_e1.last))
        else $error("run marker wrong on a two-token byte");
`endif

endmodule

`default_nettype wire
